>>> hdl/trd_pkg.sv
package trd_pkg;

	// record framing
	localparam int RECORD_LEN  = 13;
	localparam int STORE_DEPTH = RECORD_LEN - 1;
	localparam int PHASE_W     = 4;
	localparam int BYTE_W      = 8;
	localparam int DATA_BITS   = 7;
	localparam int SYNC_BIT    = 7;

	// word and result widths
	localparam int WORD_W   = 16;
	localparam int POS_W    = 17;
	localparam int MAG_W    = 16;
	localparam int MAG9_W   = 19;   // magnitude times 9, max 294912
	localparam int NUM_W    = 31;   // magnitude * range * 256
	localparam int FS_SHIFT = 15;
	localparam int FULL_SCALE = (1 << FS_SHIFT) - 1;
	localparam int NUM_BASE_SHIFT = 10;   // 36 * 256 = 9 << 10

	// config register map
	localparam logic REG_RANGE_SELECT = 1'b0;
	localparam int   RANGE_W  = 2;
	localparam logic [RANGE_W-1:0] RANGE_36  = 2'd0;
	localparam logic [RANGE_W-1:0] RANGE_72  = 2'd1;

	// m_tdata field offsets, lowest bit up
	localparam int POS_X_LSB = 0;
	localparam int POS_Y_LSB = POS_X_LSB + POS_W;
	localparam int POS_Z_LSB = POS_Y_LSB + POS_W;
	localparam int ANG_Z_LSB = POS_Z_LSB + POS_W;
	localparam int ANG_Y_LSB = ANG_Z_LSB + WORD_W;
	localparam int ANG_X_LSB = ANG_Y_LSB + WORD_W;
	localparam int IDX_LSB   = ANG_X_LSB + WORD_W;
	localparam int PAYLOAD_W = IDX_LSB + BYTE_W;
	localparam int TDATA_W   = ((PAYLOAD_W + 7) / 8) * 8;

	typedef struct packed {
		logic              neg;    // sign of the final result
		logic [MAG9_W-1:0] mag9;   // |word| * 9
	} pos_term_t;

	function automatic logic [WORD_W-1:0] word_of(
		input logic [DATA_BITS-1:0] hi,
		input logic [DATA_BITS-1:0] lo
	);
		return {hi, lo, 2'b00};
	endfunction

	function automatic logic [WORD_W-1:0] neg_sat(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] r;
		if (w == {1'b1, {(WORD_W-1){1'b0}}}) begin
			r = {1'b0, {(WORD_W-1){1'b1}}};
		end else begin
			r = WORD_W'(~w + 1'b1);
		end
		return r;
	endfunction

endpackage

>>> hdl/tracker_record_deframer.sv
// tracker_record_deframer
//
// Slave stream (s_t*): one received serial byte per request in s_tdata.
// Bytes are dropped while hunting until one has bit 7 set; that byte and
// the next 12 form a record. Only the first byte is checked for bit 7.
// Master stream (m_t*): one decoded record per 13 accepted record bytes.
// Config: APB register 0 (byte address 0) is range_select, 0 = 36 in,
// 1 = 72 in, 2 or 3 = 144 in. Write it only while the block is idle.
//
// A record is loaded into the record register (_s1) when its final
// (address) byte is accepted and then moves into the result register
// (_s2), where it is valid on m_t*. Throughput: one byte per cycle while
// s_tready is high. The x9 shift-add of each position is done before _s1;
// its range shift and /32767 with two corrections sit between _s1 and _s2.
//
// Reset (arst_n low) drops into hunting and clears both valid flags and
// range_select. When the receiver stalls, the result holds on m_t*, the
// next record waits in the _s1 register, and s_tready falls only when
// the final byte of a third record arrives with both registers full.
module tracker_record_deframer (
	input  logic                         clk,
	input  logic                         arst_n,

	// byte input
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [trd_pkg::BYTE_W-1:0]   s_tdata,   // rx_byte

	// record output
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// pos_x[16:0], pos_y, pos_z, angle_z[15:0], angle_y, angle_x,
	// tracker_index[7:0], zero pad
	output logic [trd_pkg::TDATA_W-1:0]  m_tdata,
	output logic                         m_tuser,   // index_valid

	// APB config
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	// ---------------- config register
	logic [trd_pkg::RANGE_W-1:0] range_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q <= '0;
		end else if (psel && penable && pwrite && pready
		             && paddr[2] == trd_pkg::REG_RANGE_SELECT) begin
			range_q <= pwdata[trd_pkg::RANGE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == trd_pkg::REG_RANGE_SELECT) begin
			prdata[trd_pkg::RANGE_W-1:0] = range_q;
		end
	end

	// ---------------- framing
	logic [trd_pkg::PHASE_W-1:0]   phase_q;
	logic [trd_pkg::DATA_BITS-1:0] store_q [trd_pkg::STORE_DEPTH];

	logic s1_valid_q;
	logic s2_valid_q;
	logic s1_adv;      // s1 may move into the result register
	logic final_phase;
	logic accept;
	logic s1_load;
	logic store_we;

	assign final_phase = phase_q >= trd_pkg::PHASE_W'(trd_pkg::STORE_DEPTH);
	assign s1_adv      = !s2_valid_q || m_tready;
	// only the address byte needs room downstream
	assign s_tready    = !(final_phase && s1_valid_q && !s1_adv);
	assign accept      = s_tvalid && s_tready;
	assign s1_load     = accept && final_phase;
	assign store_we    = accept && !final_phase
	                     && (phase_q != '0 || s_tdata[trd_pkg::SYNC_BIT]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (accept) begin
			if (final_phase) begin
				phase_q <= '0;
			end else if (store_we) begin
				phase_q <= phase_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < trd_pkg::STORE_DEPTH; i++) begin
			if (store_we && phase_q == trd_pkg::PHASE_W'(i)) begin
				store_q[i] <= s_tdata[trd_pkg::DATA_BITS-1:0];
			end
		end
	end

	// ---------------- record register (_s1)
	logic [trd_pkg::WORD_W-1:0] word [6];
	trd_pkg::pos_term_t         pos_term [3];

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			word[k] = trd_pkg::word_of(store_q[2*k+1], store_q[2*k]);
		end
		for (int k = 0; k < 3; k++) begin
			logic [trd_pkg::MAG_W-1:0] mag;
			mag = word[k][trd_pkg::WORD_W-1] ? trd_pkg::MAG_W'(~word[k] + 1'b1)
			                                 : word[k];
			pos_term[k].mag9 = {trd_pkg::MAG9_W'(mag) << 3} + trd_pkg::MAG9_W'(mag);
			// x is reported negated
			pos_term[k].neg  = word[k][trd_pkg::WORD_W-1] ^ (k == 0);
		end
	end

	trd_pkg::pos_term_t         pos_s1 [3];
	logic [trd_pkg::WORD_W-1:0] ang_z_s1, ang_y_s1, ang_x_s1;
	logic [trd_pkg::BYTE_W-1:0] idx_s1;
	logic                       idx_valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s1_load) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			pos_s1       <= pos_term;
			ang_z_s1     <= trd_pkg::neg_sat(word[3]);
			ang_y_s1     <= trd_pkg::neg_sat(word[4]);
			ang_x_s1     <= word[5];
			idx_valid_s1 <= s_tdata != '0;
			idx_s1       <= (s_tdata != '0) ? s_tdata - 1'b1 : '0;
		end
	end

	// ---------------- position scaling: trunc(|w| * range * 256 / 32767)
	logic [trd_pkg::POS_W-1:0] pos_res [3];
	logic [1:0]                range_sh;

	always_comb begin
		unique case (range_q)
			trd_pkg::RANGE_36: range_sh = 2'd0;
			trd_pkg::RANGE_72: range_sh = 2'd1;
			default:           range_sh = 2'd2;   // 144 in, code 3 saturates
		endcase
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic [trd_pkg::NUM_W-1:0]    num;
			logic [trd_pkg::WORD_W-1:0]   q0;
			logic [trd_pkg::POS_W-1:0]    rem;
			logic [trd_pkg::POS_W-1:0]    q;
			num = trd_pkg::NUM_W'(pos_s1[k].mag9)
			      << (trd_pkg::NUM_BASE_SHIFT + int'(range_sh));
			// N = q0 * 2^15 + b  ->  N = q0 * 32767 + (b + q0)
			q0  = num[trd_pkg::NUM_W-1 -: trd_pkg::WORD_W];
			rem = trd_pkg::POS_W'(num[trd_pkg::FS_SHIFT-1:0]) + trd_pkg::POS_W'(q0);
			q   = trd_pkg::POS_W'(q0)
			      + trd_pkg::POS_W'(rem >= trd_pkg::POS_W'(trd_pkg::FULL_SCALE))
			      + trd_pkg::POS_W'(rem >= trd_pkg::POS_W'(2 * trd_pkg::FULL_SCALE));
			pos_res[k] = pos_s1[k].neg ? trd_pkg::POS_W'(~q + 1'b1) : q;
		end
	end

	// ---------------- result register (_s2)
	logic [trd_pkg::POS_W-1:0]  pos_x_s2, pos_y_s2, pos_z_s2;
	logic [trd_pkg::WORD_W-1:0] ang_z_s2, ang_y_s2, ang_x_s2;
	logic [trd_pkg::BYTE_W-1:0] idx_s2;
	logic                       idx_valid_s2;
	logic                       s2_load;

	assign s2_load = s1_valid_q && s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s2_load) begin
			s2_valid_q <= 1'b1;
		end else if (m_tready) begin
			s2_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			pos_x_s2     <= pos_res[0];
			pos_y_s2     <= pos_res[1];
			pos_z_s2     <= pos_res[2];
			ang_z_s2     <= ang_z_s1;
			ang_y_s2     <= ang_y_s1;
			ang_x_s2     <= ang_x_s1;
			idx_s2       <= idx_s1;
			idx_valid_s2 <= idx_valid_s1;
		end
	end

	assign m_tvalid = s2_valid_q;
	assign m_tuser  = idx_valid_s2;
	assign m_tdata  = {(trd_pkg::TDATA_W - trd_pkg::PAYLOAD_W)'(0),
	                   idx_s2, ang_x_s2, ang_y_s2, ang_z_s2,
	                   pos_z_s2, pos_y_s2, pos_x_s2};

endmodule

>>> hdl/trd_checker.sv
module trd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [trd_pkg::TDATA_W-1:0] m_tdata,
	input logic                        m_tuser
);

	// a stalled result holds its payload
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// input backpressure only when the result side is stalled
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("s_tready low without output stall");

	// a fresh result must be preceded by an accepted byte
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without a final byte two cycles before");

	// angle_x keeps its two zero bits; invalid address gives index zero
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[trd_pkg::ANG_X_LSB +: 2] == 2'b00
		             && (m_tuser || m_tdata[trd_pkg::IDX_LSB +: trd_pkg::BYTE_W] == '0))
		else $error("malformed result fields");

endmodule

bind tracker_record_deframer trd_checker u_trd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
